>>> design/oversampled_frame_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef OVERSAMPLED_FRAME_DEFRAMER_MACROS_SVH
`define OVERSAMPLED_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ofd_pkg.sv
// Shared types, constants and the byte decoder for the oversampled frame deframer.
// No dependencies.
package ofd_pkg;

    localparam int EXPECT_DEPTH_DFLT = 16;
    localparam int WORD_W            = 32;
    localparam int ENTRY_W           = 64;
    localparam int DATA_BYTES        = 7;

    localparam logic [31:0] SYNC_RST  = 32'h000F_0FF0;
    localparam logic [31:0] STX_RST   = 32'h0000_00F0;
    localparam logic [31:0] ETX_RST   = 32'h0000_00FF;
    localparam logic [4:0]  OWN_RST   = 5'd1;

    typedef enum logic [1:0] {
        CFG_SYNC = 2'd0,
        CFG_STX  = 2'd1,
        CFG_ETX  = 2'd2,
        CFG_OWN  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_SYNC  = 3'd1,
        ST_STX   = 3'd2,
        ST_BYTE  = 3'd3,
        ST_DONE  = 3'd4,
        ST_ERROR = 3'd5,
        ST_STORE = 3'd6,
        ST_FULL  = 3'd7
    } t_status;

    // FIFO requests from the frame logic.
    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_req;

    // FIFO occupancy flags back to the frame logic.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // One bit per symbol: bit s of the byte is sample 4*s.
    function automatic logic [7:0] decode_byte(input logic [31:0] w);
        logic [7:0] b;
        for (int s = 0; s < 8; s++) begin
            b[s] = w[4*s];
        end
        return b;
    endfunction

endpackage

>>> design/ofd_expect_fifo.sv
// Expected-frame FIFO: one synchronous RAM, pointers and a fill level.
// The registered read port doubles as the last popped entry. Uses ofd_pkg.
`include "oversampled_frame_deframer_macros.svh"

module ofd_expect_fifo #(
    parameter int DEPTH = ofd_pkg::EXPECT_DEPTH_DFLT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ofd_pkg::t_fifo_req    i_req,
    input  logic [63:0]           i_wdata,
    output ofd_pkg::t_fifo_stat   o_stat,
    output logic [63:0]           o_rdata
);
    import ofd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [LW-1:0]      r_level;
    logic [AW-1:0]      n_wr_ptr;
    logic [AW-1:0]      n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    assign o_stat.full  = (r_level == LW'(DEPTH));
    assign o_stat.empty = (r_level == '0);
    assign o_rdata      = r_rdata;

    // RAM: write and read never target the same transaction.
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Read data only moves on a pop, so it holds the last popped frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdata <= '0;
        end else if (i_req.pop) begin
            r_rdata <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_req.push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_req.pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_req.push && !i_req.pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_req.pop && !i_req.push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    `OFD_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_req.push, !o_stat.full, "push into full FIFO")
    `OFD_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_req.pop, !o_stat.empty, "pop from empty FIFO")
    `OFD_ASSERT_NEXT(a_level_up, i_clk, i_rst_n, i_req.push && !i_req.pop, r_level == $past(r_level) + 1'b1, "level did not count push")

endmodule

>>> design/oversampled_frame_deframer.sv
// Top level of the oversampled frame deframer: frame phase logic, result pipeline.
// Depends on ofd_pkg and ofd_expect_fifo.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready): one transaction per 32-sample word
//   (i_kind = 0) or per expected frame to queue (i_kind = 1, id + 7 data bytes).
//   Output channel (o_out_valid / i_out_ready): exactly one result transaction
//   per input transaction, in order: status, receiving flag, and on frame done
//   the id, data bytes, own-address flag and compare result.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sync,
//   1 STX, 2 ETX pattern, 3 own address (low 5 data bits). Write only when idle.
//   Throughput: one transaction per cycle while the output is not stalled;
//   phase update, FIFO push and the FIFO RAM read all happen at the accept
//   edge, the 64-bit compare against the popped entry happens in the middle
//   stage, then the output register.
//   Stalls: a held output keeps the middle stage full; o_in_ready drops only
//   when both the middle stage and the output register are occupied and the
//   receiver is not taking the result.
//   Reset (synchronous, active low): phase back to sync hunt, frame cleared,
//   FIFO emptied, last popped frame zero, registers to their defaults. No
//   clearing pass: FIFO entries are only read after being written.
`include "oversampled_frame_deframer_macros.svh"

module oversampled_frame_deframer #(
    parameter int EXPECT_DEPTH = ofd_pkg::EXPECT_DEPTH_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_sample_word,
    input  logic [7:0]  i_expected_id,
    input  logic [55:0] i_expected_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic        o_receiving,
    output logic [7:0]  o_frame_id,
    output logic [55:0] o_frame_data,
    output logic        o_own_frame,
    output logic        o_frame_match,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ofd_pkg::*;

    typedef enum logic [2:0] {
        PH_SYNC = 3'd0,
        PH_STX  = 3'd1,
        PH_ID   = 3'd2,
        PH_DATA = 3'd3,
        PH_ETX  = 3'd4
    } t_phase;

    // config registers
    logic [31:0] r_sync_pat;
    logic [31:0] r_stx_pat;
    logic [31:0] r_etx_pat;
    logic [4:0]  r_own_addr;

    // frame state
    t_phase      r_phase;
    logic [7:0]  r_frame_id;
    logic [2:0]  r_data_count;
    logic [2:0]  r_data_taken;
    logic [7:0]  r_bytes [DATA_BYTES];

    t_phase      n_phase;
    logic [7:0]  n_frame_id;
    logic [2:0]  n_data_count;
    logic [2:0]  n_data_taken;
    logic [7:0]  n_bytes [DATA_BYTES];

    // result of the current transaction, before the compare stage
    t_status     n_status;
    logic [7:0]  n_res_id;
    logic [55:0] n_res_data;
    logic        n_res_own;
    logic        n_push_req;
    logic        n_pop_req;

    // middle stage and output register
    logic        r_b_valid;
    t_status     r_b_status;
    logic        r_b_receiving;
    logic [7:0]  r_b_id;
    logic [55:0] r_b_data;
    logic        r_b_own;

    logic        r_o_valid;
    t_status     r_o_status;
    logic        r_o_receiving;
    logic [7:0]  r_o_id;
    logic [55:0] r_o_data;
    logic        r_o_own;
    logic        r_o_match;

    logic        in_accept;
    logic        b_adv;
    logic        b_match;
    logic [7:0]  dec;

    t_fifo_req   fifo_req;
    t_fifo_stat  fifo_stat;
    logic [63:0] fifo_rdata;

    assign o_cfg_ready = 1'b1;
    assign b_adv       = r_b_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready  = !r_b_valid || b_adv;
    assign in_accept   = i_in_valid && o_in_ready;
    assign dec         = decode_byte(i_sample_word);

    // ---------------------------------------------------------------
    // Config writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pat <= SYNC_RST;
            r_stx_pat  <= STX_RST;
            r_etx_pat  <= ETX_RST;
            r_own_addr <= OWN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SYNC: r_sync_pat <= i_cfg_data;
                CFG_STX:  r_stx_pat  <= i_cfg_data;
                CFG_ETX:  r_etx_pat  <= i_cfg_data;
                CFG_OWN:  r_own_addr <= i_cfg_data[4:0];
                default:  r_own_addr <= r_own_addr;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Phase logic for one transaction
    // ---------------------------------------------------------------
    always_comb begin
        n_phase      = r_phase;
        n_frame_id   = r_frame_id;
        n_data_count = r_data_count;
        n_data_taken = r_data_taken;
        n_bytes      = r_bytes;
        n_status     = ST_NONE;
        n_res_id     = '0;
        n_res_data   = '0;
        n_res_own    = 1'b0;
        n_push_req   = 1'b0;
        n_pop_req    = 1'b0;

        if (i_kind) begin
            // queue an expected frame; full queue drops it
            if (fifo_stat.full) begin
                n_status = ST_FULL;
            end else begin
                n_push_req = 1'b1;
                n_status   = ST_STORE;
            end
        end else begin
            case (r_phase)
                PH_SYNC: begin
                    if (i_sample_word == r_sync_pat) begin
                        n_phase  = PH_STX;
                        n_status = ST_SYNC;
                    end
                end
                PH_STX: begin
                    if (i_sample_word == r_stx_pat) begin
                        n_phase  = PH_ID;
                        n_status = ST_STX;
                    end
                end
                PH_ID: begin
                    n_frame_id   = dec;
                    n_data_count = dec[2:0];
                    n_data_taken = '0;
                    // zero count goes straight to ETX
                    n_phase      = (dec[2:0] == 3'd0) ? PH_ETX : PH_DATA;
                    n_status     = ST_BYTE;
                end
                PH_DATA: begin
                    for (int k = 0; k < DATA_BYTES; k++) begin
                        if (r_data_taken == 3'(k)) begin
                            n_bytes[k] = dec;
                        end
                    end
                    n_data_taken = r_data_taken + 3'd1;
                    if (n_data_taken >= r_data_count) begin
                        n_phase = PH_ETX;
                    end
                    n_status = ST_BYTE;
                end
                PH_ETX: begin
                    if (i_sample_word == r_etx_pat) begin
                        n_status = ST_DONE;
                        n_res_id = r_frame_id;
                        for (int k = 0; k < DATA_BYTES; k++) begin
                            n_res_data[8*k +: 8] = r_bytes[k];
                        end
                        n_res_own = (r_frame_id[7:3] == r_own_addr);
                        // empty queue: compare against the last popped entry
                        n_pop_req = n_res_own && !fifo_stat.empty;
                    end else begin
                        n_status = ST_ERROR;
                    end
                    n_phase      = PH_SYNC;
                    n_frame_id   = '0;
                    n_data_count = '0;
                    n_data_taken = '0;
                    for (int k = 0; k < DATA_BYTES; k++) begin
                        n_bytes[k] = '0;
                    end
                end
                default: begin
                    n_phase = PH_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SYNC;
            r_frame_id   <= '0;
            r_data_count <= '0;
            r_data_taken <= '0;
            for (int k = 0; k < DATA_BYTES; k++) begin
                r_bytes[k] <= '0;
            end
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_frame_id   <= n_frame_id;
            r_data_count <= n_data_count;
            r_data_taken <= n_data_taken;
            r_bytes      <= n_bytes;
        end
    end

    // ---------------------------------------------------------------
    // Expected-frame queue; RAM read launches at the accept edge
    // ---------------------------------------------------------------
    assign fifo_req.push = in_accept && n_push_req;
    assign fifo_req.pop  = in_accept && n_pop_req;

    ofd_expect_fifo #(
        .DEPTH (EXPECT_DEPTH)
    ) u_expect_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fifo_req),
        .i_wdata ({i_expected_data, i_expected_id}),
        .o_stat  (fifo_stat),
        .o_rdata (fifo_rdata)
    );

    // ---------------------------------------------------------------
    // Compare stage and output register
    // ---------------------------------------------------------------
    // fifo_rdata holds still while the middle stage waits: no pop without accept
    assign b_match = r_b_own && ({r_b_data, r_b_id} == fifo_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_b_status    <= n_status;
            r_b_receiving <= (n_phase != PH_SYNC);
            r_b_id        <= n_res_id;
            r_b_data      <= n_res_data;
            r_b_own       <= n_res_own;
        end
        if (b_adv) begin
            r_o_status    <= r_b_status;
            r_o_receiving <= r_b_receiving;
            r_o_id        <= r_b_id;
            r_o_data      <= r_b_data;
            r_o_own       <= r_b_own;
            r_o_match     <= b_match;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_receiving   = r_o_receiving;
    assign o_frame_id    = r_o_id;
    assign o_frame_data  = r_o_data;
    assign o_own_frame   = r_o_own;
    assign o_frame_match = r_o_match;

    `OFD_ASSERT_NOW(a_taken_below_count, i_clk, i_rst_n, r_phase == PH_DATA, r_data_taken < r_data_count, "data index past count")
    `OFD_ASSERT_NOW(a_match_needs_own, i_clk, i_rst_n, r_o_valid && !r_o_own, !r_o_match, "match without own frame")
    `OFD_ASSERT_NEXT(a_b_holds, i_clk, i_rst_n, r_b_valid && !b_adv, r_b_valid && $stable(r_b_status), "middle stage lost under stall")

endmodule
